@@ hdl/fdr_pkg.sv @@
// Package for the Fresnel dielectric reflectance block.
// Holds field widths and fixed-point constants; no dependencies.
package fdr_pkg;

  localparam int FIELD_W = 16;
  localparam int CI_W = 15;
  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;
  localparam logic signed [15:0] MINUS_ONE_Q14 = -16'sd16384;
  localparam logic [28:0] ONE_Q28 = 29'h1000_0000;
  localparam logic [15:0] REFL_MAX = 16'hFFFF;
  localparam logic [16:0] RATIO_ONE = 17'h1_0000;
  localparam logic [34:0] HALF_LSB_Q33 = 35'h1_0000;

  localparam int CT2_NUM_W = 64;
  localparam int CT2_DEN_W = 32;
  localparam int CT2_Q_W = 33;
  localparam int ROOT_W = 17;
  localparam int RAT_NUM_W = 49;
  localparam int RAT_DEN_W = 34;
  localparam int RAT_Q_W = 17;
  localparam int SIDE_W = 48;

endpackage

@@ hdl/fdr_ifs.sv @@
// Stream interfaces of the Fresnel dielectric reflectance block.
// Depends on fdr_pkg for the field widths.
interface fdr_req_if;
  import fdr_pkg::*;
  logic valid;
  logic ready;
  logic signed [FIELD_W-1:0] cos_incident;
  logic [FIELD_W-1:0] eta_incident;
  logic [FIELD_W-1:0] eta_transmit;
  modport source (output valid, cos_incident, eta_incident, eta_transmit, input ready);
  modport sink (input valid, cos_incident, eta_incident, eta_transmit, output ready);
endinterface

interface fdr_rsp_if;
  import fdr_pkg::*;
  logic valid;
  logic ready;
  logic [FIELD_W-1:0] reflectance;
  logic total_reflection;
  modport source (output valid, reflectance, total_reflection, input ready);
  modport sink (input valid, reflectance, total_reflection, output ready);
endinterface

@@ hdl/fdr_div_pipe.sv @@
// Pipelined restoring divider, one quotient bit per register stage.
// Standalone; the quotient must fit in QW bits.
module fdr_div_pipe #(
  parameter int NW = 49,
  parameter int DW = 34,
  parameter int QW = 17,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QW-1:0] quot,
  output logic [SW-1:0] out_side
);
  localparam int W = (NW > DW + QW - 1) ? NW : DW + QW - 1;

  logic [W-1:0]  rem [QW+1];
  logic [DW-1:0] dv  [QW+1];
  logic [QW-1:0] qt  [QW+1];
  logic [SW-1:0] sd  [QW+1];
  logic          vl  [QW+1];

  assign rem[0] = W'(num);
  assign dv[0]  = den;
  assign qt[0]  = '0;
  assign sd[0]  = in_side;
  assign vl[0]  = in_valid;

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int K = QW - 1 - s;
    logic [W:0] trial;
    logic       ge;
    assign trial = {1'b0, rem[s]} - ((W + 1)'(dv[s]) << K);
    assign ge = !trial[W];

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[s+1] <= 1'b0;
      end else if (en) begin
        vl[s+1] <= vl[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= ge ? trial[W-1:0] : rem[s];
        qt[s+1]  <= qt[s] | (QW'(ge) << K);
        dv[s+1]  <= dv[s];
        sd[s+1]  <= sd[s];
      end
    end
  end

  assign out_valid = vl[QW];
  assign quot      = qt[QW];
  assign out_side  = sd[QW];
endmodule

@@ hdl/fdr_sqrt_pipe.sv @@
// Pipelined integer square root, one result bit per register stage.
// Standalone; gives the floor of the root of an XW-bit value.
module fdr_sqrt_pipe #(
  parameter int XW = 33,
  parameter int SW = 48,
  parameter int N = (XW + 1) / 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [XW-1:0] x,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [N-1:0]  root,
  output logic [SW-1:0] out_side
);
  localparam int RW = 2 * N + 1;

  logic [RW-1:0] xr [N+1];
  logic [RW-1:0] rr [N+1];
  logic [SW-1:0] sd [N+1];
  logic          vl [N+1];

  assign xr[0] = RW'(x);
  assign rr[0] = '0;
  assign sd[0] = in_side;
  assign vl[0] = in_valid;

  for (genvar s = 0; s < N; s++) begin : g_stage
    localparam int I = N - 1 - s;
    logic [RW-1:0] bitv;
    logic [RW-1:0] tst;
    logic          ge;
    assign bitv = RW'(1) << (2 * I);
    assign tst  = rr[s] + bitv;
    assign ge   = xr[s] >= tst;

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[s+1] <= 1'b0;
      end else if (en) begin
        vl[s+1] <= vl[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        xr[s+1] <= ge ? xr[s] - tst : xr[s];
        rr[s+1] <= ge ? (rr[s] >> 1) + bitv : rr[s] >> 1;
        sd[s+1] <= sd[s];
      end
    end
  end

  assign out_valid = vl[N];
  assign root      = rr[N][N-1:0];
  assign out_side  = sd[N];
endmodule

@@ hdl/fresnel_dielectric_reflectance.sv @@
// Unpolarized Fresnel reflectance of a dielectric interface, fully pipelined.
// Throughput: one item per cycle while the skid stage is empty. Depth: 76 register stages,
// set by the 5 front stages, the 33-stage transmitted-cosine divider, the 17-stage square
// root, 2 ratio setup stages, the 17-stage ratio dividers and 2 final stages.
// A registered skid stage holds one result while the output stalls.
// Reset (synchronous, active high) empties every stage and the skid stage.
module fresnel_dielectric_reflectance (
  input logic clk,
  input logic rst,
  fdr_req_if.sink   req,
  fdr_rsp_if.source rsp
);
  import fdr_pkg::*;

  logic en;

  logic signed [15:0] c_cl;
  logic               leaving;
  logic [15:0]        c_abs;

  logic              v1;
  logic [CI_W-1:0]   ci1;
  logic [15:0]       ei1, et1;

  logic              v2;
  logic [28:0]       ci2_2;
  logic [31:0]       ei2_2, et2_2;
  logic [CI_W-1:0]   ci_2;
  logic [15:0]       ei_2, et_2;

  logic              v3;
  logic [28:0]       sin2_3;
  logic [31:0]       ei2_3, et2_3;
  logic [CI_W-1:0]   ci_3;
  logic [15:0]       ei_3, et_3;

  logic              v4;
  logic [60:0]       lhs_4;
  logic [31:0]       et2_4;
  logic [CI_W-1:0]   ci_4;
  logic [15:0]       ei_4, et_4;

  logic [60:0]       rhs_4;
  logic [60:0]       d_4;

  logic              v5;
  logic [CT2_NUM_W-1:0] dvd_5;
  logic [31:0]       et2_5;
  logic [SIDE_W-1:0] side_5;

  logic                da_v;
  logic [CT2_Q_W-1:0]  ct2;
  logic [SIDE_W-1:0]   da_side;

  logic                sq_v;
  logic [ROOT_W-1:0]   ct;
  logic [SIDE_W-1:0]   sq_side;

  logic                tir_sq;
  logic [CI_W-1:0]     ci_sq;
  logic [15:0]         ei_sq, et_sq;
  logic [16:0]         ci16;

  logic        v6, tir6;
  logic [32:0] apar6, bpar6, aperp6, bperp6;

  logic        v7, tir7;
  logic [32:0] npar7, nperp7;
  logic [33:0] dpar7, dperp7;
  logic        zpar7, zperp7;

  logic               dp_v;
  logic [RAT_Q_W-1:0] qpar, qperp;
  logic [1:0]         dp_side;
  logic               dq_side;
  logic               dq_v;

  logic [16:0] rpar, rperp;

  logic        v8, tir8;
  logic [33:0] sqpar8, sqperp8;

  logic [34:0] sum8;
  logic [17:0] sh8;

  logic        o_v, o_tir;
  logic [15:0] o_rfl;
  logic        k_v, k_tir;
  logic [15:0] k_rfl;

  assign en = !k_v;
  assign req.ready = en;

  always_comb begin
    if (req.cos_incident > ONE_Q14) begin
      c_cl = ONE_Q14;
    end else if (req.cos_incident < MINUS_ONE_Q14) begin
      c_cl = MINUS_ONE_Q14;
    end else begin
      c_cl = req.cos_incident;
    end
    leaving = c_cl <= 16'sd0;
    c_abs = leaving ? 16'(-c_cl) : 16'(c_cl);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
      o_v <= 1'b0;
    end else if (en) begin
      v1 <= req.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= sq_v;
      v7 <= v6;
      v8 <= dp_v && dq_v;
      o_v <= v8;
    end
  end

  assign rhs_4 = {1'b0, et2_4, 28'h0};
  assign d_4   = rhs_4 - lhs_4;

  always_ff @(posedge clk) begin
    if (en) begin
      ci1 <= c_abs[CI_W-1:0];
      ei1 <= leaving ? req.eta_transmit : req.eta_incident;
      et1 <= leaving ? req.eta_incident : req.eta_transmit;

      ci2_2 <= 29'(ci1 * ci1);
      ei2_2 <= ei1 * ei1;
      et2_2 <= et1 * et1;
      ci_2 <= ci1;
      ei_2 <= ei1;
      et_2 <= et1;

      sin2_3 <= ONE_Q28 - ci2_2;
      ei2_3 <= ei2_2;
      et2_3 <= et2_2;
      ci_3 <= ci_2;
      ei_3 <= ei_2;
      et_3 <= et_2;

      lhs_4 <= 61'(sin2_3 * ei2_3);
      et2_4 <= et2_3;
      ci_4 <= ci_3;
      ei_4 <= ei_3;
      et_4 <= et_3;

      dvd_5 <= {d_4[59:0], 4'h0};
      et2_5 <= et2_4;
      side_5 <= {lhs_4 >= rhs_4, ci_4, ei_4, et_4};
    end
  end

  fdr_div_pipe #(
    .NW(CT2_NUM_W), .DW(CT2_DEN_W), .QW(CT2_Q_W), .SW(SIDE_W)
  ) u_div_ct2 (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v5), .num(dvd_5), .den(et2_5), .in_side(side_5),
    .out_valid(da_v), .quot(ct2), .out_side(da_side)
  );

  fdr_sqrt_pipe #(
    .XW(CT2_Q_W), .SW(SIDE_W)
  ) u_sqrt (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(da_v), .x(ct2), .in_side(da_side),
    .out_valid(sq_v), .root(ct), .out_side(sq_side)
  );

  assign {tir_sq, ci_sq, ei_sq, et_sq} = sq_side;
  assign ci16 = {ci_sq, 2'b00};

  always_ff @(posedge clk) begin
    if (en) begin
      tir6 <= tir_sq;
      apar6 <= 33'(et_sq * ci16);
      bpar6 <= 33'(ei_sq * ct);
      aperp6 <= 33'(ei_sq * ci16);
      bperp6 <= 33'(et_sq * ct);

      tir7 <= tir6;
      npar7 <= (apar6 >= bpar6) ? apar6 - bpar6 : bpar6 - apar6;
      nperp7 <= (aperp6 >= bperp6) ? aperp6 - bperp6 : bperp6 - aperp6;
      dpar7 <= 34'(apar6) + 34'(bpar6);
      dperp7 <= 34'(aperp6) + 34'(bperp6);
      zpar7 <= (apar6 == '0) && (bpar6 == '0);
      zperp7 <= (aperp6 == '0) && (bperp6 == '0);
    end
  end

  fdr_div_pipe #(
    .NW(RAT_NUM_W), .DW(RAT_DEN_W), .QW(RAT_Q_W), .SW(2)
  ) u_div_par (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v7), .num({npar7, 16'h0}), .den(dpar7), .in_side({tir7, zpar7}),
    .out_valid(dp_v), .quot(qpar), .out_side(dp_side)
  );

  fdr_div_pipe #(
    .NW(RAT_NUM_W), .DW(RAT_DEN_W), .QW(RAT_Q_W), .SW(1)
  ) u_div_perp (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v7), .num({nperp7, 16'h0}), .den(dperp7), .in_side(zperp7),
    .out_valid(dq_v), .quot(qperp), .out_side(dq_side)
  );

  assign rpar  = (dp_side[0] || (qpar > RATIO_ONE)) ? RATIO_ONE : qpar;
  assign rperp = (dq_side || (qperp > RATIO_ONE)) ? RATIO_ONE : qperp;

  assign sum8 = 35'(sqpar8) + 35'(sqperp8) + HALF_LSB_Q33;
  assign sh8  = sum8[34:17];

  always_ff @(posedge clk) begin
    if (en) begin
      tir8 <= dp_side[1];
      sqpar8 <= rpar * rpar;
      sqperp8 <= rperp * rperp;

      o_tir <= tir8;
      if (tir8 || (sh8 > 18'(REFL_MAX))) begin
        o_rfl <= REFL_MAX;
      end else begin
        o_rfl <= sh8[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k_v <= 1'b0;
    end else if (k_v) begin
      if (rsp.ready) begin
        k_v <= 1'b0;
      end
    end else if (o_v && !rsp.ready) begin
      k_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!k_v) begin
      k_rfl <= o_rfl;
      k_tir <= o_tir;
    end
  end

  assign rsp.valid = k_v || o_v;
  assign rsp.reflectance = k_v ? k_rfl : o_rfl;
  assign rsp.total_reflection = k_v ? k_tir : o_tir;
endmodule

@@ tb/tb_fresnel_dielectric_reflectance.sv @@
// Testbench for the Fresnel dielectric reflectance block: a directed table then random rays,
// each result checked against an in-bench reflectance predictor or a fixed table value, with random stalls.
// Depends on fdr_pkg, the fdr_req_if/fdr_rsp_if interfaces and the block itself.
module tb_fresnel_dielectric_reflectance;
  timeunit 1ns;
  timeprecision 1ps;
  import fdr_pkg::*;

  typedef struct packed {
    logic [15:0] refl;
    logic        tir;
  } refl_t;

  typedef struct {
    logic signed [15:0] c;
    logic [15:0]        ei;
    logic [15:0]        et;
    bit                 has_exp;
    refl_t              exp_val;
  } ray_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  fdr_req_if req();
  fdr_rsp_if rsp();

  fresnel_dielectric_reflectance uut (.clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source));

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  refl_t pending_refl[$];
  int errors = 0;
  int n_rays = 0;
  int n_results = 0;
  int n_tir = 0;
  bit stim_done = 1'b0;

  function automatic logic [31:0] isqrt64(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[31:0];
  endfunction

  function automatic logic [63:0] ratio_q16(logic [63:0] a, logic [63:0] b);
    logic [63:0] num, den, q;
    num = (a >= b) ? a - b : b - a;
    den = a + b;
    if (den == 0) return 64'd65536;
    q = (num << 16) / den;
    return (q > 64'd65536) ? 64'd65536 : q;
  endfunction

  function automatic refl_t fresnel_refl(logic signed [15:0] cos_in, logic [15:0] ein,
                                         logic [15:0] etn);
    int c;
    logic [63:0] ei, et, ci, s2, lhs, et2, rhs, ct2, ct, ci16, rpar, rperp, sum;
    refl_t r;
    c = cos_in;
    ei = ein;
    et = etn;
    if (c > 16384) c = 16384;
    if (c < -16384) c = -16384;
    if (c <= 0) begin
      ei = etn;
      et = ein;
      ci = -c;
    end else begin
      ci = c;
    end
    s2 = (64'd1 << 28) - ci * ci;
    lhs = s2 * (ei * ei);
    et2 = et * et;
    rhs = et2 << 28;
    if (lhs >= rhs) begin
      r.refl = REFL_MAX;
      r.tir = 1'b1;
      return r;
    end
    ct2 = (et2 != 0) ? ((rhs - lhs) << 4) / et2 : 0;
    ct = isqrt64(ct2);
    ci16 = ci << 2;
    rpar = ratio_q16(et * ci16, ei * ct);
    rperp = ratio_q16(ei * ci16, et * ct);
    sum = (rpar * rpar + rperp * rperp + (64'd1 << 16)) >> 17;
    if (sum > 65535) sum = 65535;
    r.refl = sum[15:0];
    r.tir = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  task automatic send_ray(logic signed [15:0] c, logic [15:0] ei, logic [15:0] et);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid <= 1'b1;
    req.cos_incident <= c;
    req.eta_incident <= ei;
    req.eta_transmit <= et;
    do @(posedge clk); while (!req.ready);
    pending_refl.push_back(fresnel_refl(c, ei, et));
    n_rays++;
    @(negedge clk);
  endtask

  ray_row_t ray_table[] = '{
    '{16'sh7FFF, 16'd8192, 16'd8192, 1'b1, '{16'd0, 1'b0}},
    '{-16'sh8000, 16'd8192, 16'd8192, 1'b1, '{16'd0, 1'b0}},
    '{16'sd16384, 16'd8192, 16'd12288, 1'b0, '{16'd0, 1'b0}},
    '{-16'sd16384, 16'd8192, 16'd12288, 1'b0, '{16'd0, 1'b0}},
    '{16'sd0, 16'd8192, 16'd12288, 1'b0, '{16'd0, 1'b0}},
    '{16'sd1000, 16'd12288, 16'd8192, 1'b0, '{16'd0, 1'b0}},
    '{16'sd100, 16'd65535, 16'd1, 1'b1, '{16'hFFFF, 1'b1}},
    '{16'sd8000, 16'd8192, 16'd0, 1'b1, '{16'hFFFF, 1'b1}},
    '{16'sd8000, 16'd0, 16'd8192, 1'b0, '{16'd0, 1'b0}},
    '{16'sd1, 16'd65535, 16'd65535, 1'b0, '{16'd0, 1'b0}},
    '{16'sd16384, 16'd1, 16'd65535, 1'b0, '{16'd0, 1'b0}},
    '{-16'sd1, 16'd8192, 16'd20000, 1'b0, '{16'd0, 1'b0}},
    '{16'sd11585, 16'd12288, 16'd8192, 1'b0, '{16'd0, 1'b0}},
    '{16'sd0, 16'd0, 16'd0, 1'b0, '{16'd0, 1'b0}},
    '{16'sh5555, 16'hAAAA, 16'h5555, 1'b0, '{16'd0, 1'b0}},
    '{-16'sh2AAA, 16'h5555, 16'hAAAA, 1'b0, '{16'd0, 1'b0}}
  };

  initial begin
    logic signed [15:0] c;
    logic [15:0] ei, et;
    int k;
    req.valid = 1'b0;
    req.cos_incident = '0;
    req.eta_incident = '0;
    req.eta_transmit = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (ray_table[i]) begin
      send_ray(ray_table[i].c, ray_table[i].ei, ray_table[i].et);
      if (ray_table[i].has_exp) pending_refl[$] = ray_table[i].exp_val;
    end
    for (int i = 0; i < 400; i++) begin
      k = $urandom_range(0, 9);
      if (k < 6)
        c = 16'($signed($urandom_range(0, 32768)) - 16384);
      else
        c = 16'($urandom);
      if (k < 8) begin
        ei = 16'($urandom_range(4096, 24576));
        et = 16'($urandom_range(4096, 24576));
      end else begin
        ei = 16'($urandom);
        et = 16'($urandom);
      end
      send_ray(c, ei, et);
    end
    req.valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    rsp.ready = 1'b0;
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 40) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(10, 40)) @(negedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    refl_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      n_results++;
      if (pending_refl.size() == 0) begin
        $display("result with no ray outstanding: reflectance %0d", rsp.reflectance);
        errors++;
      end else begin
        want = pending_refl.pop_front();
        if (rsp.total_reflection) n_tir++;
        if (rsp.reflectance !== want.refl)
          report_mismatch("reflectance", rsp.reflectance, want.refl);
        if (rsp.total_reflection !== want.tir)
          report_mismatch("total_reflection", rsp.total_reflection, want.tir);
      end
    end
  end

  initial begin
    wait (stim_done);
    while (pending_refl.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Sent %0d rays, checked %0d results, %0d with total reflection.",
             n_rays, n_results, n_tir);
    if (errors == 0 && pending_refl.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin
    #2ms;
    $display("TB_ERROR");
    $finish;
  end
endmodule
